// ===== hw/rtl/session_pid_table_top_defines.svh =====
// Assertion macros for the session pid table.
// Used by session_pid_table_top; expects clk and rst in scope.
`ifndef SESSION_PID_TABLE_TOP_DEFINES_SVH
`define SESSION_PID_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session table check failed");
`define SPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session table check failed");
`else
`define SPT_ASSERT_IMP(lbl, ante, cons)
`define SPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/spt_pkg.sv =====
// Shared types and constants for the session pid table.
// No dependencies.
package spt_pkg;

  localparam int NUM_SLOTS     = 16;
  localparam int PIDS_PER_SLOT = 16;
  localparam int RESULT_CAP    = 16;
  localparam int SLOT_W        = 4;
  localparam int PIDX_W        = 4;
  localparam int CNT_W         = 5;
  localparam int K_W           = 4;
  localparam int MEM_DEPTH     = NUM_SLOTS * PIDS_PER_SLOT;
  localparam logic [31:0] BAD_ID = 32'd0;

  localparam logic [1:0] SS_TERM     = 2'd0;
  localparam logic [1:0] SS_ACTIVE   = 2'd1;
  localparam logic [1:0] SS_INACTIVE = 2'd2;

  typedef enum logic [3:0] {
    F_CREATE    = 4'd0,
    F_DESTROY   = 4'd1,
    F_SUSPEND   = 4'd2,
    F_RESUME    = 4'd3,
    F_ADD       = 4'd4,
    F_REMOVE    = 4'd5,
    F_BY_ID     = 4'd6,
    F_BY_PID    = 4'd7,
    F_BY_USER   = 4'd8,
    F_BY_INDEX  = 4'd9,
    F_TOUCH     = 4'd10,
    F_IS_LEADER = 4'd11,
    F_COUNT     = 4'd12
  } func_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] sess_id;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [31:0] proc_id;
    logic [3:0]  slot_index;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] out_sess_id;
    logic [31:0] out_uid;
    logic [31:0] out_gid;
    logic [31:0] leader;
    logic [1:0]  sess_state;
    logic [4:0]  member_count;
    logic [31:0] activity;
    logic [31:0] signal_pid;
    logic [4:0]  total_sessions;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    MOP_NONE, MOP_CREATE, MOP_END, MOP_SUSPEND, MOP_RESUME,
    MOP_ADD, MOP_REMOVE, MOP_LEADER, MOP_TOUCH
  } mop_t;

  typedef enum logic [1:0] {RA_MP, RA_MP1, RA_ZERO} rd_sel_t;
  typedef enum logic [1:0] {SIG_ZERO, SIG_RDATA, SIG_LEADER} sig_sel_t;

  typedef struct packed {
    logic     latch;
    logic     sp_clr;
    logic     sp_inc;
    logic     sp_idx;
    logic     mp_clr;
    logic     mp_inc;
    logic     k_inc;
    rd_sel_t  rd_sel;
    logic     wr_en;
    logic     wr_rdata;
    mop_t     mop;
    logic     emit;
    logic     emit_ok;
    logic     emit_show;
    sig_sel_t emit_sig;
    logic     emit_last;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  slot_hit;
    logic  sp_last;
    logic  valid_sp;
    logic  mp_lt_cnt;
    logic  mp1_lt_cnt;
    logic  cnt_full;
    logic  cnt_zero;
    logic  rd_eq_pid;
    logic  rd_eq_leader;
    logic  pid_eq_leader;
    logic  st_active;
    logic  st_inactive;
    logic  k_full;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_SS, S_P_SLOT, S_P_CMP, S_H_SLOT, S_H_CMP,
    S_R_CHK, S_R_WR, S_R_END, S_R_LEAD, S_D_SLOT, S_D_CMP, S_D_LAST,
    S_IDX, S_FIN
  } ctrl_state_t;

endpackage

// ===== hw/rtl/spt_dp.sv =====
// Datapath of the session pid table: slot registers, member pid memory,
// scan pointers and result register. Depends on spt_pkg.
module spt_dp import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  input  request_t req_in,
  output dp_stat_t stat,
  output result_t  result,
  output logic     result_valid
);

  request_t            req;
  logic [SLOT_W-1:0]   sp;
  logic [CNT_W-1:0]    mp;
  logic [K_W-1:0]      k;
  logic                slot_valid [NUM_SLOTS];
  logic [1:0]          slot_state [NUM_SLOTS];
  logic [CNT_W-1:0]    slot_count [NUM_SLOTS];
  logic [31:0]         slot_sess_id [NUM_SLOTS];
  logic [31:0]         slot_uid [NUM_SLOTS];
  logic [31:0]         slot_gid [NUM_SLOTS];
  logic [31:0]         slot_leader [NUM_SLOTS];
  logic [31:0]         slot_activity [NUM_SLOTS];
  logic [31:0]         member_pids [MEM_DEPTH];
  logic [31:0]         rdata;
  logic [31:0]         next_id;
  logic [CNT_W-1:0]    live_count;
  logic [31:0]         nid;
  logic [PIDX_W-1:0]   rd_idx;
  logic [31:0]         wr_data;
  logic [CNT_W-1:0]    cnt_sp;
  logic [31:0]         sig;
  result_t             res_next;

  assign cnt_sp  = slot_count[sp];
  assign nid     = (next_id + 32'd1 == BAD_ID) ? 32'd1 : next_id + 32'd1;
  assign wr_data = cmd.wr_rdata ? rdata : req.proc_id;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_MP:   rd_idx = mp[PIDX_W-1:0];
      RA_MP1:  rd_idx = PIDX_W'(mp + CNT_W'(1));
      RA_ZERO: rd_idx = '0;
      default: rd_idx = mp[PIDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= member_pids[{sp, rd_idx}];
    if (cmd.wr_en) begin
      member_pids[{sp, mp[PIDX_W-1:0]}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_in;
    end
    unique case (cmd.mop)
      MOP_CREATE: begin
        slot_sess_id[sp]  <= next_id;
        slot_uid[sp]      <= req.user_id;
        slot_gid[sp]      <= req.group_id;
        slot_leader[sp]   <= req.proc_id;
        slot_activity[sp] <= 32'd0;
      end
      MOP_LEADER: slot_leader[sp] <= rdata;
      MOP_TOUCH:  slot_activity[sp] <= slot_activity[sp] + 32'd1;
      default: ;
    endcase
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_state[i] <= SS_TERM;
        slot_count[i] <= '0;
      end
      next_id      <= 32'd1;
      live_count   <= '0;
      sp           <= '0;
      mp           <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.latch || cmd.sp_clr) begin
        sp <= '0;
      end else if (cmd.sp_idx) begin
        sp <= req.slot_index;
      end else if (cmd.sp_inc) begin
        sp <= sp + SLOT_W'(1);
      end
      if (cmd.latch || cmd.mp_clr) begin
        mp <= '0;
      end else if (cmd.mp_inc) begin
        mp <= mp + CNT_W'(1);
      end
      if (cmd.latch) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + K_W'(1);
      end
      unique case (cmd.mop)
        MOP_CREATE: begin
          slot_state[sp] <= SS_ACTIVE;
          slot_valid[sp] <= 1'b1;
          slot_count[sp] <= CNT_W'(1);
          next_id        <= nid;
          live_count     <= live_count + CNT_W'(1);
        end
        MOP_END: begin
          slot_state[sp] <= SS_TERM;
          slot_valid[sp] <= 1'b0;
          live_count     <= live_count - CNT_W'(1);
        end
        MOP_SUSPEND: slot_state[sp] <= SS_INACTIVE;
        MOP_RESUME:  slot_state[sp] <= SS_ACTIVE;
        MOP_ADD:     slot_count[sp] <= cnt_sp + CNT_W'(1);
        MOP_REMOVE:  slot_count[sp] <= cnt_sp - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.func = func_t'(req.func);
    unique case (func_t'(req.func))
      F_CREATE: stat.slot_hit = !slot_valid[sp];
      F_DESTROY, F_SUSPEND, F_RESUME, F_ADD, F_BY_ID:
        stat.slot_hit = slot_valid[sp] && (slot_sess_id[sp] == req.sess_id);
      F_BY_USER:
        stat.slot_hit = slot_valid[sp] && (slot_uid[sp] == req.user_id)
                        && (slot_state[sp] == SS_ACTIVE);
      F_IS_LEADER:
        stat.slot_hit = slot_valid[sp] && (slot_leader[sp] == req.proc_id);
      default: stat.slot_hit = 1'b0;
    endcase
    stat.sp_last       = (sp == SLOT_W'(NUM_SLOTS - 1));
    stat.valid_sp      = slot_valid[sp];
    stat.mp_lt_cnt     = (mp < cnt_sp);
    stat.mp1_lt_cnt    = ((mp + CNT_W'(1)) < cnt_sp);
    stat.cnt_full      = (cnt_sp >= CNT_W'(PIDS_PER_SLOT));
    stat.cnt_zero      = (cnt_sp == '0);
    stat.rd_eq_pid     = (rdata == req.proc_id);
    stat.rd_eq_leader  = (rdata == slot_leader[sp]);
    stat.pid_eq_leader = (req.proc_id == slot_leader[sp]);
    stat.st_active     = (slot_state[sp] == SS_ACTIVE);
    stat.st_inactive   = (slot_state[sp] == SS_INACTIVE);
    stat.k_full        = (k == K_W'(RESULT_CAP - 1));
  end

  always_comb begin
    unique case (cmd.emit_sig)
      SIG_RDATA:  sig = rdata;
      SIG_LEADER: sig = slot_leader[sp];
      default:    sig = 32'd0;
    endcase
    res_next = '0;
    res_next.ok = cmd.emit_ok;
    if (cmd.emit_show) begin
      res_next.slot         = sp;
      res_next.out_sess_id  = slot_sess_id[sp];
      res_next.out_uid      = slot_uid[sp];
      res_next.out_gid      = slot_gid[sp];
      res_next.leader       = slot_leader[sp];
      res_next.sess_state   = slot_state[sp];
      res_next.member_count = cnt_sp;
      res_next.activity     = slot_activity[sp];
    end
    res_next.signal_pid     = sig;
    res_next.total_sessions = live_count;
    res_next.last           = cmd.emit_last;
  end

endmodule

// ===== hw/rtl/spt_ctrl.sv =====
// Controller of the session pid table: sequences slot and member scans.
// Depends on spt_pkg; drives spt_dp through dp_cmd_t.
module spt_ctrl import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  ctrl_state_t state, state_next;
  logic        fin_ok, fin_ok_next;
  logic        fin_show, fin_show_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_ok   <= 1'b0;
      fin_show <= 1'b0;
    end else begin
      state    <= state_next;
      fin_ok   <= fin_ok_next;
      fin_show <= fin_show_next;
    end
  end

  always_comb begin
    state_next    = state;
    fin_ok_next   = fin_ok;
    fin_show_next = fin_show;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.func)
          F_CREATE, F_REMOVE, F_BY_PID, F_TOUCH: state_next = S_P_SLOT;
          F_DESTROY, F_SUSPEND, F_RESUME, F_ADD, F_BY_ID, F_BY_USER, F_IS_LEADER:
            state_next = S_SS;
          F_BY_INDEX: begin
            cmd.sp_idx = 1'b1;
            state_next = S_IDX;
          end
          F_COUNT: begin
            fin_ok_next = 1'b1; fin_show_next = 1'b0; state_next = S_FIN;
          end
          default: begin
            fin_ok_next = 1'b0; fin_show_next = 1'b0; state_next = S_FIN;
          end
        endcase
      end
      S_SS: begin
        if (stat.slot_hit) begin
          fin_show_next = 1'b1;
          fin_ok_next   = 1'b1;
          state_next    = S_FIN;
          unique case (stat.func)
            F_CREATE: begin
              cmd.mop    = MOP_CREATE;
              cmd.wr_en  = 1'b1;
            end
            F_DESTROY: begin
              cmd.mop    = MOP_END;
              state_next = S_D_SLOT;
            end
            F_SUSPEND: begin
              if (stat.st_active) cmd.mop = MOP_SUSPEND;
              else fin_ok_next = 1'b0;
            end
            F_RESUME: begin
              if (stat.st_inactive) cmd.mop = MOP_RESUME;
              else fin_ok_next = 1'b0;
            end
            F_ADD: state_next = S_H_SLOT;
            default: ;
          endcase
        end else if (stat.sp_last) begin
          fin_ok_next = 1'b0; fin_show_next = 1'b0; state_next = S_FIN;
        end else begin
          cmd.sp_inc = 1'b1;
        end
      end
      S_P_SLOT: begin
        if (stat.valid_sp && stat.mp_lt_cnt) begin
          cmd.rd_sel = RA_MP;
          state_next = S_P_CMP;
        end else if (stat.sp_last) begin
          if (stat.func == F_CREATE) begin
            cmd.sp_clr = 1'b1;
            cmd.mp_clr = 1'b1;
            state_next = S_SS;
          end else begin
            fin_ok_next = 1'b0; fin_show_next = 1'b0; state_next = S_FIN;
          end
        end else begin
          cmd.sp_inc = 1'b1;
          cmd.mp_clr = 1'b1;
        end
      end
      S_P_CMP: begin
        if (stat.rd_eq_pid) begin
          fin_ok_next   = 1'b1;
          fin_show_next = 1'b1;
          state_next    = S_FIN;
          unique case (stat.func)
            F_CREATE: begin
              fin_ok_next = 1'b0; fin_show_next = 1'b0;
            end
            F_REMOVE: state_next = S_R_CHK;
            F_TOUCH:  cmd.mop = MOP_TOUCH;
            default: ;
          endcase
        end else begin
          cmd.mp_inc = 1'b1;
          state_next = S_P_SLOT;
        end
      end
      S_H_SLOT: begin
        fin_show_next = 1'b1;
        if (stat.mp_lt_cnt) begin
          cmd.rd_sel = RA_MP;
          state_next = S_H_CMP;
        end else if (stat.cnt_full) begin
          fin_ok_next = 1'b0; state_next = S_FIN;
        end else begin
          cmd.mop     = MOP_ADD;
          cmd.wr_en   = 1'b1;
          fin_ok_next = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_H_CMP: begin
        if (stat.rd_eq_pid) begin
          fin_ok_next = 1'b0; fin_show_next = 1'b1; state_next = S_FIN;
        end else begin
          cmd.mp_inc = 1'b1;
          state_next = S_H_SLOT;
        end
      end
      S_R_CHK: begin
        if (stat.mp1_lt_cnt) begin
          cmd.rd_sel = RA_MP1;
          state_next = S_R_WR;
        end else begin
          cmd.mop    = MOP_REMOVE;
          state_next = S_R_END;
        end
      end
      S_R_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.mp_inc   = 1'b1;
        state_next   = S_R_CHK;
      end
      S_R_END: begin
        fin_ok_next = 1'b1; fin_show_next = 1'b1; state_next = S_FIN;
        if (stat.cnt_zero) begin
          cmd.mop = MOP_END;
        end else if (stat.pid_eq_leader) begin
          cmd.rd_sel = RA_ZERO;
          state_next = S_R_LEAD;
        end
      end
      S_R_LEAD: begin
        cmd.mop    = MOP_LEADER;
        state_next = S_FIN;
      end
      S_D_SLOT: begin
        if (stat.mp_lt_cnt) begin
          cmd.rd_sel = RA_MP;
          state_next = S_D_CMP;
        end else begin
          state_next = S_D_LAST;
        end
      end
      S_D_CMP: begin
        if (!stat.rd_eq_leader && !stat.k_full) begin
          cmd.emit      = 1'b1;
          cmd.emit_ok   = 1'b1;
          cmd.emit_show = 1'b1;
          cmd.emit_sig  = SIG_RDATA;
          cmd.k_inc     = 1'b1;
        end
        cmd.mp_inc = 1'b1;
        state_next = S_D_SLOT;
      end
      S_D_LAST: begin
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        cmd.emit_show = 1'b1;
        cmd.emit_sig  = SIG_LEADER;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_IDX: begin
        fin_ok_next   = stat.valid_sp;
        fin_show_next = stat.valid_sp;
        state_next    = S_FIN;
      end
      S_FIN: begin
        cmd.emit      = 1'b1;
        cmd.emit_ok   = fin_ok;
        cmd.emit_show = fin_show;
        cmd.emit_sig  = SIG_ZERO;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/session_pid_table_top.sv =====
// Session pid table top level: controller plus datapath.
// Depends on spt_pkg, spt_ctrl, spt_dp and session_pid_table_top_defines.svh.
//
//   port group              dir  handshake
//   start/busy/request      in   taken when start && !busy
//   result_valid/result     out  one-cycle strobe, no back pressure
//
// Slot-field operations (by id, user, leader, suspend, resume, count,
// index) do not touch the member memory; by id, user, leader, suspend and
// resume scan the slots in order; pid searches read and compare each
// stored pid of every valid slot in turn. Destroy emits a result per
// non-leader member, up to the cap, then one for the leader; remove shifts
// later pids down. Reset is synchronous and needs no clearing pass.
`include "session_pid_table_top_defines.svh"
module session_pid_table_top import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  spt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_in       (request),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  `SPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SPT_ASSERT_IMP(a_last_idle, result_valid && result.last, !busy)
  `SPT_ASSERT_IMP(a_mid_busy, result_valid && !result.last, busy && result.ok)
  `SPT_ASSERT_IMP(a_fail_nosig, result_valid && !result.ok, result.signal_pid == 32'd0)

endmodule
